// ----- src/assert_macros.svh -----
// Assertion macros for the RTL, included by waveform_frame_decoder_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr)
`endif
`endif

// ----- src/wfd_pkg.sv -----
// Types and constants for the waveform frame decoder.
package wfd_pkg;

    localparam logic [7:0] HDR_BYTE       = 8'hA3;
    localparam logic [7:0] MODE_POINT     = 8'hA8;
    localparam logic [7:0] MODE_SYNC      = 8'hA9;
    localparam logic [7:0] MODE_INFO      = 8'hAA;
    localparam logic [7:0] MAX_SYNC_RESET = 8'd64;
    localparam logic [7:0] INFO_LEN       = 8'd8;

    localparam logic [1:0] FMT_F32 = 2'd0;
    localparam logic [1:0] FMT_I8  = 2'd1;
    localparam logic [1:0] FMT_I16 = 2'd2;
    localparam logic [1:0] FMT_I32 = 2'd3;

    localparam logic       KIND_SAMPLE = 1'b0;
    localparam logic       KIND_TSTAMP = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_HEAD     = 6'b000010,
        ST_POINT    = 6'b000100,
        ST_SYNC     = 6'b001000,
        ST_INFO     = 6'b010000,
        ST_SYNCDATA = 6'b100000
    } parse_state_t;

    // Result payload, packed to match m_axis_tdata (channel in the low bits).
    typedef struct packed {
        logic [1:0]  pad;
        logic [20:0] sample_rate;
        logic [9:0]  millisecond;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [6:0]  year;
        logic [31:0] sample_bits;
        logic [1:0]  sample_format;
        logic [3:0]  channel;
    } result_t;

    // Number of data bytes that follow a type byte.
    function automatic logic [2:0] fmt_bytes(input logic [1:0] fmt);
        logic [2:0] n;
        case (fmt)
            FMT_F32: n = 3'd4;
            FMT_I8:  n = 3'd1;
            FMT_I16: n = 3'd2;
            FMT_I32: n = 3'd4;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

// ----- src/waveform_frame_decoder_top.sv -----
// Waveform frame decoder: byte stream in, sample and timestamp records out.
//
// Input: s_axis_* carries one received byte per transfer. The decoder hunts for
// header 0xA3 and a mode byte, then decodes point frames (one sample), sync
// frames (a run of samples, length byte checked against max_sync_length) or
// info frames (8 bytes unpacked into a timestamp record).
// Output: m_axis_* carries one record per transfer; tuser is the record kind
// (0 sample, 1 timestamp), tdata holds the unpacked fields.
// A record is registered onto m_axis in the cycle after the byte that ends it.
// Throughput: one byte per cycle unless m_axis stalls; all parsing is
// combinational logic between the byte handshake and the output register.
// Reset clears the parser to the hunting state, the assembler and counters,
// sets max_sync_length to 64 and empties the output register.
// When the receiver stalls with a record pending, s_axis_tready stays high
// only in the cycle the record is taken; bytes are otherwise held off.
// cfg_wr_en/cfg_wr_data write max_sync_length; write only while idle.
module waveform_frame_decoder_top
    import wfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] channel, [5:4] sample_format, [37:6] sample_bits, [44:38] year,
    // [48:45] month, [53:49] day, [58:54] hour, [64:59] minute,
    // [70:65] second, [80:71] millisecond, [101:81] sample_rate, [103:102] 0
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tuser    // [0] record_kind
);

    parse_state_t state_reg, state_next;
    logic [7:0]   max_sync_reg;
    logic [2:0]   pcnt_reg, pcnt_next;
    logic [2:0]   plen_reg, plen_next;
    logic [3:0]   pch_reg, pch_next;
    logic [1:0]   pfmt_reg, pfmt_next;
    logic [31:0]  shift_reg, shift_next;
    logic [7:0]   fcnt_reg, fcnt_next;
    logic [7:0]   slen_reg, slen_next;
    logic [7:0]   info_reg [0:6];
    logic         out_valid_reg;
    result_t      out_data_reg;
    logic         out_kind_reg;

    logic         in_xfer;
    logic [7:0]   b;
    logic         push;
    result_t      res;
    logic         res_kind;
    logic         info_wr;

    // point assembler helpers
    logic [31:0]  feed_shift;
    logic         feed_fail;
    logic         feed_done;
    logic [31:0]  feed_val;
    logic [7:0]   fcnt_inc;
    logic         sync_end;
    result_t      smp_res;
    result_t      ts_res;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign b             = s_axis_tdata;
    assign fcnt_inc      = fcnt_reg + 8'd1;
    assign sync_end      = (fcnt_inc >= slen_reg);

    always_comb
    begin
        feed_shift = {shift_reg[23:0], b};
        feed_fail  = (pcnt_reg == 3'd0) && (b[7:6] != 2'd0);
        feed_done  = (pcnt_reg != 3'd0) && (pcnt_reg >= plen_reg);
        case (pfmt_reg)
            FMT_I8:  feed_val = {{24{feed_shift[7]}}, feed_shift[7:0]};
            FMT_I16: feed_val = {{16{feed_shift[15]}}, feed_shift[15:0]};
            default: feed_val = feed_shift;
        endcase

        smp_res               = '0;
        smp_res.channel       = pch_reg;
        smp_res.sample_format = pfmt_reg;
        smp_res.sample_bits   = feed_val;

        // last info byte comes straight from the input
        ts_res             = '0;
        ts_res.year        = info_reg[0][7:1];
        ts_res.month       = {info_reg[0][0], info_reg[1][7:5]};
        ts_res.day         = info_reg[1][4:0];
        ts_res.hour        = info_reg[2][7:3];
        ts_res.minute      = {info_reg[2][2:0], info_reg[3][7:5]};
        ts_res.second      = {info_reg[3][4:0], info_reg[4][7]};
        ts_res.millisecond = {info_reg[4][6:0], info_reg[5][7:5]};
        ts_res.sample_rate = {info_reg[5][4:0], info_reg[6], b};
    end

    always_comb
    begin
        state_next = state_reg;
        pcnt_next  = pcnt_reg;
        plen_next  = plen_reg;
        pch_next   = pch_reg;
        pfmt_next  = pfmt_reg;
        shift_next = shift_reg;
        fcnt_next  = fcnt_reg;
        slen_next  = slen_reg;
        push       = 1'b0;
        res        = smp_res;
        res_kind   = KIND_SAMPLE;
        info_wr    = 1'b0;

        if (in_xfer)
        begin
            // shared point feed; overridden below where the frame ends
            if (state_reg == ST_POINT || state_reg == ST_SYNCDATA)
            begin
                if (pcnt_reg == 3'd0)
                begin
                    pch_next = b[3:0];
                    if (feed_fail)
                    begin
                        shift_next = '0;
                    end
                    else
                    begin
                        pfmt_next = b[5:4];
                        plen_next = fmt_bytes(b[5:4]);
                        pcnt_next = 3'd1;
                    end
                end
                else if (feed_done)
                begin
                    pcnt_next  = 3'd0;
                    shift_next = '0;
                end
                else
                begin
                    shift_next = feed_shift;
                    pcnt_next  = pcnt_reg + 3'd1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (b == HDR_BYTE)
                        state_next = ST_HEAD;
                end
                ST_HEAD:
                begin
                    pcnt_next  = 3'd0;
                    shift_next = '0;
                    if (b == MODE_POINT)
                        state_next = ST_POINT;
                    else if (b == MODE_SYNC)
                        state_next = ST_SYNC;
                    else if (b == MODE_INFO)
                    begin
                        state_next = ST_INFO;
                        fcnt_next  = '0;
                    end
                    else
                        state_next = ST_IDLE;
                end
                ST_POINT:
                begin
                    if (feed_fail || feed_done)
                        state_next = ST_IDLE;
                    push = feed_done;
                end
                ST_SYNC:
                begin
                    fcnt_next  = '0;
                    slen_next  = b;
                    state_next = (b <= max_sync_reg) ? ST_SYNCDATA : ST_IDLE;
                end
                ST_SYNCDATA:
                begin
                    fcnt_next = fcnt_inc;
                    if (feed_fail || sync_end)
                        state_next = ST_IDLE;
                    push = feed_done;
                    // partial sample dropped at end of run
                    if (!feed_done && sync_end)
                    begin
                        pcnt_next  = 3'd0;
                        shift_next = '0;
                    end
                end
                ST_INFO:
                begin
                    info_wr = (fcnt_reg[2:0] != 3'd7);
                    if (fcnt_inc >= INFO_LEN)
                    begin
                        push       = 1'b1;
                        res        = ts_res;
                        res_kind   = KIND_TSTAMP;
                        fcnt_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        fcnt_next = fcnt_inc;
                end
                default:
                begin
                    state_next = ST_IDLE;
                    pcnt_next  = 3'd0;
                    shift_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_sync_reg  <= MAX_SYNC_RESET;
            pcnt_reg      <= '0;
            plen_reg      <= '0;
            pch_reg       <= '0;
            pfmt_reg      <= '0;
            shift_reg     <= '0;
            fcnt_reg      <= '0;
            slen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pcnt_reg  <= pcnt_next;
            plen_reg  <= plen_next;
            pch_reg   <= pch_next;
            pfmt_reg  <= pfmt_next;
            shift_reg <= shift_next;
            fcnt_reg  <= fcnt_next;
            slen_reg  <= slen_next;
            if (cfg_wr_en)
                max_sync_reg <= cfg_wr_data;
            if (push)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (info_wr)
            info_reg[fcnt_reg[2:0]] <= b;
        if (push)
        begin
            out_data_reg <= res;
            out_kind_reg <= res_kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

`include "assert_macros.svh"

    // a record always ends its frame or one sample of a sync run
    `ASSERT_AT(a_push_state, clk, rst_n,
        push |=> (state_reg == ST_IDLE || state_reg == ST_SYNCDATA))
    `ASSERT_NEVER(a_pcnt_range, clk, rst_n, pcnt_reg > 3'd4)
    `ASSERT_AT(a_info_cnt, clk, rst_n, (state_reg == ST_INFO) |-> (fcnt_reg < INFO_LEN))
    `ASSERT_AT(a_stall_only_full, clk, rst_n, !s_axis_tready |-> out_valid_reg)

endmodule
